[src/metropolis_acceptance_annealer_top_defines.svh]
// Assertion macros used by the annealer datapath
`ifndef METROPOLIS_ACCEPTANCE_ANNEALER_TOP_DEFINES_SVH
`define METROPOLIS_ACCEPTANCE_ANNEALER_TOP_DEFINES_SVH
// Implication checked on every edge out of reset
`define MAA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define MAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/maa_pkg.sv]
// Types, constants and exponent table for the Metropolis annealer
package maa_pkg;
    localparam int CHAINS          = 8;
    localparam int CHAIN_W         = 3;
    localparam int RECENT_WINDOW   = 64;
    localparam int WIN_IDX_W       = $clog2(RECENT_WINDOW);
    localparam int WIN_CNT_W       = 7;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam logic [31:0] PREV_RESET = 32'd40960000;
    localparam logic [12:0] LOG2E_Q12  = 13'd5909;
    localparam logic [15:0] TEMP_RESET = 16'd100;
    localparam logic [15:0] IDEAL_RESET = 16'd16384;
    localparam logic [15:0] MARGIN_RESET = 16'd3277;
    localparam int DIV_STEPS = 33;

    localparam logic [1:0] OP_ACCEPT = 2'd0;
    localparam logic [1:0] OP_ANNEAL = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_IDEAL  = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  chain;
        logic [31:0] trial;
        logic [15:0] uniform_draw;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        temp_changed;
        logic [15:0] temperature;
        logic [31:0] accept_count;
        logic [31:0] trial_count;
        logic [6:0]  window_ones;
        logic [6:0]  window_fill;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat, start compare
        logic div_start; // seed the divider
        logic div_step;  // one quotient bit
        logic mul_step;  // product and table lookup
        logic decide;    // commit accept decision
        logic anneal;    // commit anneal step
        logic clear;     // clear statistics
        logic finish;    // build result beat
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       chain_ok;
        logic       need_div;
    } t_sts;

    typedef logic [63:0] t_u64;
    typedef logic [16:0] t_exp_table [EXP_TABLE_DEPTH];

    localparam t_u64 ROOT_FACTOR [13] = '{
        64'd1073741824, 64'd759250125, 64'd902905651, 64'd984625594,
        64'd1028218713, 64'd1050733751, 64'd1062175491, 64'd1067942999,
        64'd1070838486, 64'd1072289172, 64'd1073015252, 64'd1073378477,
        64'd1073560135
    };

    // 2^-(q/4096) in Q1.16, evaluated at elaboration for the constant table
    function automatic logic [16:0] pow2_neg(input logic [11:0] q);
        t_u64 acc;
        acc = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            if (q[12-k])
                acc = (acc * ROOT_FACTOR[k] + (64'd1 << 29)) >> 30;
        end
        acc = (acc + (64'd1 << 13)) >> 14;
        return acc[16:0];
    endfunction

    function automatic logic [16:0] exp_entry(input logic [EXP_IDX_W-1:0] idx);
        logic [31:0] q;
        q = (32'(idx) * 32'd4096) / EXP_TABLE_DEPTH;
        return pow2_neg(q[11:0]);
    endfunction

    function automatic t_exp_table build_exp_table();
        t_exp_table tbl;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            tbl[i] = exp_entry(EXP_IDX_W'(i));
        return tbl;
    endfunction

    // exponent table, constant after elaboration
    localparam t_exp_table EXP_TABLE = build_exp_table();
endpackage

[src/metropolis_acceptance_annealer_top.sv]
// Metropolis annealer top level: configuration port, controller and datapath
// Usage:
//   Input channel i_in_valid/o_in_ready carries one t_in_item beat per item;
//   output channel o_out_valid/i_out_ready returns exactly one t_out_item.
//   An accept item needing the exponent test passes through compare, the
//   radix-2 divider (one quotient bit per step), product/table, decide and
//   result build. Other items skip the divider. One item is in flight at a
//   time, and the next item may be taken in the cycle the result appears.
//   Reset (synchronous, i_rst_n low) clears chain counts and the window, sets previous
//   values to 40960000 and restores temperature 100 and the register defaults.
//   A stalled receiver holds the result register; no further item enters
//   until the result is taken (the next item may enter in that same cycle).
//   APB registers: 0x0 start temperature, 0x4 ideal rate, 0x8 margin;
//   write only while idle.
module metropolis_acceptance_annealer_top
    import maa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_start, r_ideal, r_margin;
    logic        wr;
    logic [1:0]  reg_idx;
    t_cmd        cmd;
    t_sts        sts;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= TEMP_RESET; r_ideal <= IDEAL_RESET; r_margin <= MARGIN_RESET;
        end else if (wr) begin
            unique case (reg_idx)
                REG_START:  r_start  <= pwdata[15:0];
                REG_IDEAL:  r_ideal  <= pwdata[15:0];
                REG_MARGIN: r_margin <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START:  prdata = {16'd0, r_start};
            REG_IDEAL:  prdata = {16'd0, r_ideal};
            REG_MARGIN: prdata = {16'd0, r_margin};
            default:    prdata = '0;
        endcase
    end

    maa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    maa_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_in(i_in_data),
        .i_temp_load(wr && reg_idx == REG_START), .i_temp_value(pwdata[15:0]),
        .i_ideal(r_ideal), .i_margin(r_margin), .o_sts(sts), .o_out(o_out_data)
    );
endmodule

[src/maa_ctrl.sv]
// Sequencer for the annealer: handshakes and per-item command steps
module maa_ctrl
    import maa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_MUL, S_DEC, S_DONE} t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    // item may enter while the previous result is being taken from the output register
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (i_sts.opcode)
                    OP_ACCEPT: begin
                        if (!i_sts.chain_ok) n_state = S_DONE;
                        else if (i_sts.need_div) begin
                            o_cmd.div_start = 1'b1;
                            n_cnt   = 6'd0;
                            n_state = S_DIV;
                        end else n_state = S_DEC;
                    end
                    OP_ANNEAL: begin o_cmd.anneal = 1'b1; n_state = S_DONE; end
                    OP_CLEAR:  begin o_cmd.clear = 1'b1; n_state = S_DONE; end
                    default:   n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_MUL;
            end
            S_MUL: begin o_cmd.mul_step = 1'b1; n_state = S_DEC; end
            S_DEC: begin o_cmd.decide = 1'b1; n_state = S_DONE; end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

[src/maa_datapath.sv]
// Datapath: chain state, divider, exponent threshold, window and temperature
module maa_datapath
    import maa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in,
    input  logic      i_temp_load,
    input  logic [15:0] i_temp_value,
    input  logic [15:0] i_ideal,
    input  logic [15:0] i_margin,
    output t_sts      o_sts,
    output t_out_item o_out
);
    logic [31:0] r_prev [CHAINS];
    logic [31:0] r_acc_cnt [CHAINS];
    logic [31:0] r_trl_cnt [CHAINS];
    // newest decision at bit 0, oldest of a full window at the top bit
    logic [RECENT_WINDOW-1:0] r_bits;
    logic [WIN_CNT_W-1:0] r_fill, r_ones;
    logic [15:0] r_temp;
    t_in_item    r_item;
    t_out_item   r_out;
    logic        r_accept, r_changed;
    // divider
    logic [32:0] r_rem, r_quo;
    logic [32:0] r_num;
    logic [16:0] r_thr;
    logic        r_big;

    logic [31:0] prev_sel;
    logic [32:0] diff;
    logic [33:0] rem_sh;
    logic [46:0] prod;
    logic [33:0] y;
    logic [16:0] entry;
    logic        dec_bit;
    logic [WIN_CNT_W-1:0] ones_nx;
    logic [39:0] lhs, hi, lo;
    logic [16:0] sum_ir;

    assign prev_sel = r_prev[r_item.chain];
    assign diff     = {1'b0, r_item.trial} - {1'b0, prev_sel};
    assign o_sts.opcode   = r_item.opcode;
    assign o_sts.chain_ok = 1'b1;
    assign o_sts.need_div = r_item.trial > prev_sel;

    // restoring divide step
    assign rem_sh = {r_rem, r_num[32]};

    // y = x*log2e >> 12, with x below 2^33 so the product fits 46 bits
    assign prod  = 47'(r_quo) * 47'(LOG2E_Q12);
    assign y     = prod[45:12];
    assign entry = EXP_TABLE[y[11:12-EXP_IDX_W]];

    assign dec_bit = !o_sts.need_div ||
                     (!r_big && ({1'b0, r_item.uniform_draw} < r_thr));
    assign ones_nx = r_ones + WIN_CNT_W'(dec_bit)
                   - ((r_fill == WIN_CNT_W'(RECENT_WINDOW)) ?
                      WIN_CNT_W'(r_bits[RECENT_WINDOW-1]) : '0);

    // anneal rate comparison
    assign sum_ir = {1'b0, i_ideal} + {1'b0, i_margin};
    assign lhs    = {17'd0, r_ones, 16'd0};
    assign hi     = 40'(sum_ir) * 40'(r_fill);
    assign lo     = 40'(i_ideal - i_margin) * 40'(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHAINS; i++) begin
                r_prev[i] <= PREV_RESET;
                r_acc_cnt[i] <= '0;
                r_trl_cnt[i] <= '0;
            end
            r_bits <= '0; r_fill <= '0; r_ones <= '0;
            r_temp <= TEMP_RESET;
            r_accept <= 1'b0; r_changed <= 1'b0;
        end else begin
            if (i_temp_load) r_temp <= (i_temp_value == 16'd0) ? 16'd1 : i_temp_value;
            if (i_cmd.load) begin
                r_accept <= 1'b0; r_changed <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_accept <= dec_bit;
                if (r_trl_cnt[r_item.chain] != '1)
                    r_trl_cnt[r_item.chain] <= r_trl_cnt[r_item.chain] + 32'd1;
                if (dec_bit) begin
                    r_prev[r_item.chain] <= r_item.trial;
                    if (r_acc_cnt[r_item.chain] != '1)
                        r_acc_cnt[r_item.chain] <= r_acc_cnt[r_item.chain] + 32'd1;
                end
                r_ones <= ones_nx;
                r_bits <= {r_bits[RECENT_WINDOW-2:0], dec_bit};
                if (r_fill < WIN_CNT_W'(RECENT_WINDOW))
                    r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.anneal && r_fill != '0) begin
                if (lhs > hi) begin
                    if (r_temp > 16'd1) begin r_temp <= r_temp - 16'd1; r_changed <= 1'b1; end
                end else if (i_ideal >= i_margin && lhs < lo) begin
                    if (r_temp != 16'hFFFF) begin
                        r_temp <= r_temp + 16'd1; r_changed <= 1'b1;
                    end
                end
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < CHAINS; i++) begin
                    r_prev[i] <= PREV_RESET;
                    r_acc_cnt[i] <= '0;
                    r_trl_cnt[i] <= '0;
                end
                r_bits <= '0; r_fill <= '0; r_ones <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in;
        if (i_cmd.div_start) begin
            r_num <= diff; r_rem <= '0; r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[31:0], 1'b0};
            if (rem_sh >= {18'd0, r_temp}) begin
                r_rem <= 33'(rem_sh - {18'd0, r_temp});
                r_quo <= {r_quo[31:0], 1'b1};
            end else begin
                r_rem <= rem_sh[32:0];
                r_quo <= {r_quo[31:0], 1'b0};
            end
        end
        if (i_cmd.mul_step) begin
            r_big <= (y[33:12] >= 22'd17);
            r_thr <= entry >> y[16:12];
        end
        if (i_cmd.finish) begin
            r_out.accepted     <= r_accept;
            r_out.temp_changed <= r_changed;
            r_out.temperature  <= r_temp;
            r_out.accept_count <= r_acc_cnt[r_item.chain];
            r_out.trial_count  <= r_trl_cnt[r_item.chain];
            r_out.window_ones  <= r_ones;
            r_out.window_fill  <= r_fill;
        end
    end

    assign o_out = r_out;

`include "metropolis_acceptance_annealer_top_defines.svh"
    `MAA_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= WIN_CNT_W'(RECENT_WINDOW))
    `MAA_ASSERT_IMP(a_ones_bound, i_clk, i_rst_n, 1'b1, r_ones <= r_fill)
    `MAA_ASSERT_IMP(a_temp_nz, i_clk, i_rst_n, 1'b1, r_temp != 16'd0)
    `MAA_ASSERT_NEXT(a_clear, i_clk, i_rst_n, i_cmd.clear, r_fill == '0 && r_ones == '0)
endmodule

[tb/sv/tb_metropolis_acceptance_annealer_checker.sv]
// Scoreboard for the Metropolis annealer: predicts each result beat and compares it
`timescale 1ns / 1ps
module tb_metropolis_acceptance_annealer_checker
    import maa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_val,
    output int        o_fail_count,
    output int        o_pending
);
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;
    localparam int EXP_DEPTH = 16;
    localparam logic [63:0] ROOT [13] = '{
        64'd1073741824, 64'd759250125, 64'd902905651, 64'd984625594,
        64'd1028218713, 64'd1050733751, 64'd1062175491, 64'd1067942999,
        64'd1070838486, 64'd1072289172, 64'd1073015252, 64'd1073378477,
        64'd1073560135
    };

    logic [31:0] last_val [CHAINS];
    logic [31:0] acc_cnt [CHAINS];
    logic [31:0] try_cnt [CHAINS];
    logic [15:0] temp_q;
    logic [15:0] ideal_q;
    logic [15:0] margin_q;
    logic        win_bits [RECENT_WINDOW];
    int          win_fill;
    int          win_ones;
    int          win_head;
    logic [16:0] exp_lut [EXP_TABLE_DEPTH];
    // expected beats in order, ring with free-running indices
    t_out_item   exp_ring [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = exp_wr - exp_rd;

    // 2^-(q/4096) in Q1.16 from root factors
    function automatic logic [16:0] two_pow_neg(input int q);
        logic [63:0] a;
        a = 64'd1 << 30;
        for (int k = 1; k <= 12; k++)
            if ((q >> (12 - k)) & 1) a = (a * ROOT[k] + (64'd1 << 29)) >> 30;
        a = (a + (64'd1 << 13)) >> 14;
        return a[16:0];
    endfunction

    task automatic reset_stats();
        for (int i = 0; i < CHAINS; i++) begin
            last_val[i] = PREV_RESET;
            acc_cnt[i]  = 0;
            try_cnt[i]  = 0;
        end
        for (int i = 0; i < RECENT_WINDOW; i++) win_bits[i] = 1'b0;
        win_fill = 0;
        win_ones = 0;
        win_head = 0;
    endtask

    function automatic logic metropolis_ok(input int c, input logic [31:0] tr,
                                           input logic [15:0] u);
        logic [63:0] d, x, y, n, idx, thr;
        if (tr <= last_val[c]) return 1'b1;
        d = 64'(tr) - 64'(last_val[c]);
        x = d / 64'(temp_q);
        y = (x * 64'd5909) >> 12;
        n = y >> 12;
        if (n >= 17) return 1'b0;
        idx = ((y & 64'd4095) * EXP_TABLE_DEPTH) >> 12;
        thr = 64'(exp_lut[idx % EXP_TABLE_DEPTH]) >> n;
        return 64'(u) < thr;
    endfunction

    // Advance the predicted state by one input beat
    task automatic predict_result(input t_in_item it);
        t_out_item r;
        logic [63:0] lhs, hi;
        int c;
        r = '0;
        c = it.chain;
        case (it.opcode)
            OP_ACCEPT: begin
                r.accepted = metropolis_ok(c, it.trial, it.uniform_draw);
                if (try_cnt[c] != SAT) try_cnt[c]++;
                if (r.accepted) begin
                    if (acc_cnt[c] != SAT) acc_cnt[c]++;
                    last_val[c] = it.trial;
                end
                if (win_fill < RECENT_WINDOW) begin
                    win_bits[(win_head + win_fill) % RECENT_WINDOW] = r.accepted;
                    win_fill++;
                    win_ones += r.accepted;
                end else begin
                    win_ones -= win_bits[win_head];
                    win_bits[win_head] = r.accepted;
                    win_ones += r.accepted;
                    win_head = (win_head + 1) % RECENT_WINDOW;
                end
            end
            OP_ANNEAL: begin
                if (win_fill != 0) begin
                    lhs = 64'(win_ones) << 16;
                    hi  = (64'(ideal_q) + 64'(margin_q)) * 64'(win_fill);
                    if (lhs > hi) begin
                        if (temp_q > 1) begin
                            temp_q--;
                            r.temp_changed = 1'b1;
                        end
                    end else if (ideal_q >= margin_q &&
                                 lhs < 64'(ideal_q - margin_q) * 64'(win_fill)) begin
                        if (temp_q < 16'hFFFF) begin
                            temp_q++;
                            r.temp_changed = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: reset_stats();
            default: ;
        endcase
        r.temperature  = temp_q;
        r.accept_count = acc_cnt[c];
        r.trial_count  = try_cnt[c];
        r.window_ones  = 7'(win_ones);
        r.window_fill  = 7'(win_fill);
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    initial begin
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            exp_lut[i] = two_pow_neg((i * 4096) / EXP_TABLE_DEPTH);
        fails = 0;
    end

    // Track configuration, inputs and outputs at each edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            temp_q   = TEMP_RESET;
            ideal_q  = IDEAL_RESET;
            margin_q = MARGIN_RESET;
            reset_stats();
            exp_wr = 0;
            exp_rd = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START:  temp_q = (i_cfg_val == 0) ? 16'd1 : i_cfg_val;
                    REG_IDEAL:  ideal_q = i_cfg_val;
                    REG_MARGIN: margin_q = i_cfg_val;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result beat %p", i_out_data);
                end else begin
                    want = exp_ring[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (want !== i_out_data) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p actual %p", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_result(i_in_data);
        end
    end
endmodule

[tb/sv/tb_metropolis_acceptance_annealer_top.sv]
// Stimulus and verdict for the Metropolis annealer top level
`timescale 1ns / 1ps
module tb_metropolis_acceptance_annealer_top;
    import maa_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_off = 1'b0;
    int          quiet_cycles = 0;
    logic [31:0] chain_last [CHAINS];

    metropolis_acceptance_annealer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_metropolis_acceptance_annealer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[3:2]), .i_cfg_val(pwdata[15:0]),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no accepted beat and no register access
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb_metropolis_acceptance_annealer_top: FAIL");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(65535)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender pauses until every expected result has come
    task automatic wait_results();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // Wait until all results are in, then let the block settle
    task automatic drain();
        wait_results();
        repeat (50) @(posedge i_clk);
    endtask

    // valid stays high after an accepted beat until the next beat or an idle cycle
    task automatic send_beat(input logic [1:0] op, input logic [2:0] ch,
                             input logic [31:0] tr, input logic [15:0] u);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, chain: ch, trial: tr, uniform_draw: u};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (op == OP_ACCEPT) chain_last[ch] = tr;
    endtask

    // Mostly trials near the chain's last value so the exponent path is exercised
    task automatic random_beat();
        logic [1:0]  op;
        logic [2:0]  ch;
        logic [31:0] tr;
        int sel;
        sel = $urandom_range(99);
        op  = sel < 70 ? OP_ACCEPT : sel < 85 ? OP_ANNEAL : sel < 88 ? OP_CLEAR : OP_READ;
        ch  = 3'($urandom_range(7));
        case ($urandom_range(3))
            0: tr = $urandom;
            1: tr = chain_last[ch] - $urandom_range(5000);
            default: tr = chain_last[ch] + $urandom_range(1 << $urandom_range(22));
        endcase
        send_beat(op, ch, tr, 16'($urandom_range(65535)));
    endtask

    initial begin
        for (int i = 0; i < CHAINS; i++) chain_last[i] = PREV_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_stall_pct = 0;

        // Directed: field extremes, every operation, window and limits
        send_beat(OP_ANNEAL, 3'd0, 32'd0, 16'd0);
        send_beat(OP_ACCEPT, 3'd0, 32'd0, 16'hFFFF);
        send_beat(OP_ACCEPT, 3'd0, 32'hFFFF_FFFF, 16'd0);
        send_beat(OP_ACCEPT, 3'd7, 32'd40960001, 16'hFFFF);
        send_beat(OP_ACCEPT, 3'd7, 32'd40961000, 16'd0);
        send_beat(OP_ACCEPT, 3'd1, 32'd40960000, 16'h8000);
        send_beat(OP_ACCEPT, 3'd2, 32'd41000000, 16'd100);
        send_beat(OP_READ, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(OP_ANNEAL, 3'd0, 32'd0, 16'd0);
        send_beat(OP_CLEAR, 3'd5, 32'd0, 16'd0);
        send_beat(OP_READ, 3'd0, 32'd0, 16'd0);
        for (int i = 0; i < 70; i++) send_beat(OP_ACCEPT, 3'(i), 32'd0, 16'd0);
        drain();
        reg_write(REG_START, 16'd0);
        reg_write(REG_IDEAL, 16'd0);
        reg_write(REG_MARGIN, 16'd0);
        send_beat(OP_ANNEAL, 3'd0, 32'd0, 16'd0);
        send_beat(OP_ANNEAL, 3'd0, 32'd0, 16'd0);
        drain();
        reg_write(REG_START, 16'hFFFF);
        reg_write(REG_IDEAL, 16'hFFFF);
        reg_write(REG_MARGIN, 16'd10);
        send_beat(OP_CLEAR, 3'd0, 32'd0, 16'd0);
        send_beat(OP_ACCEPT, 3'd4, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(OP_ANNEAL, 3'd4, 32'd0, 16'd0);
        send_beat(OP_ANNEAL, 3'd4, 32'd0, 16'd0);

        // Random phases with different idling and settings
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            reg_write(REG_START, ph == 4 ? 16'd1 : 16'($urandom_range(1, 3000)));
            reg_write(REG_IDEAL, 16'($urandom_range(65535)));
            reg_write(REG_MARGIN, ph == 4 ? 16'hFFFF : 16'($urandom_range(8000)));
            if (ph == 2) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 200; i++) begin
                random_beat();
                if (i == 100) wait_results();
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_metropolis_acceptance_annealer_top: PASS");
        else
            $display("tb_metropolis_acceptance_annealer_top: FAIL");
        $finish;
    end
endmodule
